[rtl/core/tchs_pkg.sv]
// ----------------------------------------------------------------------------
// tchs_pkg
// Shared types and constants for the ternary CAM Hamming-distance search.
// ----------------------------------------------------------------------------
`default_nettype none

package tchs_pkg;

    // default sizes
    localparam int DEF_ROWS      = 16;
    localparam int DEF_WORD_BITS = 32;

    // fixed field widths
    localparam int IN_WORD_W  = 32;
    localparam int ROW_IN_W   = 4;
    localparam int ROW_OUT_W  = 4;
    localparam int COUNT_W    = 6;
    localparam int ROW_ID_W   = 6;   // holds any row of the largest array
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int MODE_W     = 2;
    localparam int ACTIVE_W   = 5;

    // opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXMIS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd2;

    // search modes; the unused code behaves as exact
    localparam logic [MODE_W-1:0] MODE_EXACT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_THRESH = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

    // row read request into the row store
    typedef struct packed {
        logic                rd;
        logic [ROW_ID_W-1:0] row;
    } t_scan_req;

    // mismatch count coming back from the row store
    typedef struct packed {
        logic                valid;
        logic [ROW_ID_W-1:0] row;
        logic [COUNT_W-1:0]  count;
    } t_scan_rsp;

endpackage

`default_nettype wire

[rtl/core/tchs_row_store.sv]
// ----------------------------------------------------------------------------
// tchs_row_store
// Ternary row memory (value and care) with a pipelined mismatch counter:
// read, per-byte popcount, lane sum, each stage registered in that order.
// ----------------------------------------------------------------------------
`default_nettype none

module tchs_row_store #(
    parameter int ROWS      = tchs_pkg::DEF_ROWS,
    parameter int WORD_BITS = tchs_pkg::DEF_WORD_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_wr_en,
    input  wire logic [tchs_pkg::ROW_IN_W-1:0]     i_wr_index,
    input  wire logic [WORD_BITS-1:0]              i_wr_value,
    input  wire logic [WORD_BITS-1:0]              i_wr_care,
    input  wire logic [WORD_BITS-1:0]              i_query,
    input  wire tchs_pkg::t_scan_req               i_req,
    output tchs_pkg::t_scan_rsp                    o_rsp
);

    localparam int AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LANES = (WORD_BITS + 7) / 8;
    localparam int PAD_W = LANES * 8;

    logic [WORD_BITS-1:0] mem_value [ROWS];
    logic [WORD_BITS-1:0] mem_care  [ROWS];

    logic [WORD_BITS-1:0] r_rd_value;
    logic [WORD_BITS-1:0] r_rd_care;
    logic                 r_s1_vld;
    logic [tchs_pkg::ROW_ID_W-1:0] r_s1_row;
    logic [3:0]           r_lane [LANES];
    logic [3:0]           n_lane [LANES];
    logic                 r_s2_vld;
    logic [tchs_pkg::ROW_ID_W-1:0] r_s2_row;
    logic                 r_s3_vld;
    logic [tchs_pkg::ROW_ID_W-1:0] r_s3_row;
    logic [tchs_pkg::COUNT_W-1:0]  r_s3_count;
    logic [tchs_pkg::COUNT_W-1:0]  n_s3_count;

    logic [6:0]           wr_idx_ext;
    logic                 wr_ok;
    logic [PAD_W-1:0]     diff_pad;
    logic [6:0]           lane_sum;

    // write port: rows beyond the array are dropped
    assign wr_idx_ext = 7'(i_wr_index);
    assign wr_ok      = (wr_idx_ext < 7'(ROWS));

    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_ok) begin
            mem_value[wr_idx_ext[AW-1:0]] <= i_wr_value;
            mem_care[wr_idx_ext[AW-1:0]]  <= i_wr_care;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_rd_value <= mem_value[i_req.row[AW-1:0]];
            r_rd_care  <= mem_care[i_req.row[AW-1:0]];
        end
    end

    // cared-for differing bits, one popcount per byte lane
    assign diff_pad = PAD_W'((r_rd_value ^ i_query) & r_rd_care);

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_lane[l] = 4'd0;
            for (int b = 0; b < 8; b++) begin
                n_lane[l] = n_lane[l] + 4'(diff_pad[l*8 + b]);
            end
        end
    end

    // sum of lanes, saturated to the count field
    always_comb begin
        lane_sum = 7'd0;
        for (int l = 0; l < LANES; l++) begin
            lane_sum = lane_sum + 7'(r_lane[l]);
        end
        if (lane_sum > 7'(tchs_pkg::COUNT_MAX)) begin
            n_s3_count = tchs_pkg::COUNT_MAX;
        end else begin
            n_s3_count = lane_sum[tchs_pkg::COUNT_W-1:0];
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_s1_row   <= i_req.row;
        r_lane     <= n_lane;
        r_s2_row   <= r_s1_row;
        r_s3_row   <= r_s2_row;
        r_s3_count <= n_s3_count;
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_req.rd;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    assign o_rsp.valid = r_s3_vld;
    assign o_rsp.row   = r_s3_row;
    assign o_rsp.count = r_s3_count;

endmodule

`default_nettype wire

[rtl/core/tchs_count_ram.sv]
// ----------------------------------------------------------------------------
// tchs_count_ram
// Per-row mismatch counts of the running search; one write and one
// registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tchs_count_ram #(
    parameter int ROWS = tchs_pkg::DEF_ROWS,
    localparam int AW  = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_we,
    input  wire logic [AW-1:0]                  i_waddr,
    input  wire logic [tchs_pkg::COUNT_W-1:0]   i_wdata,
    input  wire logic                           i_re,
    input  wire logic [AW-1:0]                  i_raddr,
    output logic      [tchs_pkg::COUNT_W-1:0]   o_rdata
);

    logic [tchs_pkg::COUNT_W-1:0] mem [ROWS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/ternary_cam_hamming_search_top.sv]
// Search of N active rows: every row is counted through the row memory
// pipeline, then N results on consecutive cycles are read back from the
// count memory. busy stays high for the whole search, so a new command is
// taken only once the previous search is done. A row write does not set
// busy. Results cannot be stalled. Reset clears control and the
// configuration registers; stored rows are undefined until written.
// ----------------------------------------------------------------------------
// ternary_cam_hamming_search_top
// Ternary CAM with Hamming-distance search: exact, best and threshold modes.
// ----------------------------------------------------------------------------
`default_nettype none

module ternary_cam_hamming_search_top #(
    parameter int ROWS      = tchs_pkg::DEF_ROWS,
    parameter int WORD_BITS = tchs_pkg::DEF_WORD_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // command channel
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                i_opcode,
    input  wire logic [tchs_pkg::ROW_IN_W-1:0]       i_row_index,
    input  wire logic [tchs_pkg::IN_WORD_W-1:0]      i_row_value,
    input  wire logic [tchs_pkg::IN_WORD_W-1:0]      i_row_care,
    input  wire logic [tchs_pkg::IN_WORD_W-1:0]      i_query,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [tchs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [tchs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // results
    output logic                                     o_valid,
    output logic      [tchs_pkg::ROW_OUT_W-1:0]      o_result_row,
    output logic      [tchs_pkg::COUNT_W-1:0]        o_mismatch_count,
    output logic                                     o_hit,
    output logic                                     o_last
);

    localparam int AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W = $clog2(ROWS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state                            r_state;
    logic [CNT_W-1:0]                  r_issue;
    logic [CNT_W-1:0]                  r_rows;
    logic [WORD_BITS-1:0]              r_query;
    logic [tchs_pkg::COUNT_W-1:0]      r_best;
    logic                              r_em_vld;
    logic [AW-1:0]                     r_em_row;

    logic [tchs_pkg::MODE_W-1:0]       r_mode;
    logic [tchs_pkg::COUNT_W-1:0]      r_max;
    logic [tchs_pkg::ACTIVE_W-1:0]     r_active;

    logic                              accept;
    logic                              wr_en;
    logic [6:0]                        act_ext;
    logic [6:0]                        n_rows_ext;
    logic                              issue_ok;
    tchs_pkg::t_scan_req               scan_req;
    tchs_pkg::t_scan_rsp               scan_rsp;
    logic                              scan_last;
    logic                              em_rd;
    logic [tchs_pkg::COUNT_W-1:0]      em_count;
    logic                              em_last;
    logic                              n_hit;
    logic [tchs_pkg::ROW_ID_W-1:0]     em_row_ext;

    // command transfer
    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign wr_en  = accept && (i_opcode == tchs_pkg::OP_WRITE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= tchs_pkg::MODE_EXACT;
            r_max    <= '0;
            r_active <= 5'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tchs_pkg::CFG_MODE:   r_mode   <= i_cfg_wdata[tchs_pkg::MODE_W-1:0];
                tchs_pkg::CFG_MAXMIS: r_max    <= i_cfg_wdata;
                tchs_pkg::CFG_ACTIVE: r_active <= i_cfg_wdata[tchs_pkg::ACTIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // active row count clamped to 1..ROWS
    assign act_ext = 7'(r_active);
    always_comb begin
        if (act_ext == 7'd0) begin
            n_rows_ext = 7'd1;
        end else if (act_ext > 7'(ROWS)) begin
            n_rows_ext = 7'(ROWS);
        end else begin
            n_rows_ext = act_ext;
        end
    end

    // row issue for both passes
    assign issue_ok       = (r_issue < r_rows);
    assign scan_req.rd    = (r_state == S_SCAN) && issue_ok;
    assign scan_req.row   = tchs_pkg::ROW_ID_W'(r_issue[AW-1:0]);
    assign em_rd          = (r_state == S_EMIT) && issue_ok;

    tchs_row_store #(
        .ROWS      (ROWS),
        .WORD_BITS (WORD_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_index (i_row_index),
        .i_wr_value (WORD_BITS'(i_row_value)),
        .i_wr_care  (WORD_BITS'(i_row_care)),
        .i_query    (r_query),
        .i_req      (scan_req),
        .o_rsp      (scan_rsp)
    );

    tchs_count_ram #(
        .ROWS (ROWS)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (scan_rsp.valid),
        .i_waddr (scan_rsp.row[AW-1:0]),
        .i_wdata (scan_rsp.count),
        .i_re    (em_rd),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (em_count)
    );

    assign scan_last = (7'(scan_rsp.row) == (7'(r_rows) - 7'd1));
    assign em_last   = (7'(r_em_row) == (7'(r_rows) - 7'd1));
    assign em_row_ext = tchs_pkg::ROW_ID_W'(r_em_row);

    // hit rule of the current mode
    always_comb begin
        unique case (r_mode)
            tchs_pkg::MODE_BEST:   n_hit = (em_count == r_best);
            tchs_pkg::MODE_THRESH: n_hit = (em_count <= r_max);
            default:               n_hit = (em_count == '0);
        endcase
    end

    // search payload, held for the whole search; result output registers
    always_ff @(posedge i_clk) begin
        if (accept && (i_opcode == tchs_pkg::OP_SEARCH)) begin
            r_query <= WORD_BITS'(i_query);
            r_rows  <= CNT_W'(n_rows_ext);
        end
        r_em_row         <= r_issue[AW-1:0];
        o_result_row     <= em_row_ext[tchs_pkg::ROW_OUT_W-1:0];
        o_mismatch_count <= em_count;
        o_hit            <= n_hit;
        o_last           <= em_last;
    end

    // sequencer: count pass, then result pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issue  <= '0;
            r_best   <= '0;
            r_em_vld <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_em_vld <= em_rd;
            o_valid  <= r_em_vld;
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_opcode == tchs_pkg::OP_SEARCH)) begin
                        r_state <= S_SCAN;
                        r_issue <= '0;
                        r_best  <= tchs_pkg::COUNT_MAX;
                    end
                end
                S_SCAN: begin
                    if (scan_req.rd) begin
                        r_issue <= r_issue + CNT_W'(1);
                    end
                    if (scan_rsp.valid) begin
                        if (scan_rsp.count < r_best) begin
                            r_best <= scan_rsp.count;
                        end
                        if (scan_last) begin
                            r_state <= S_EMIT;
                            r_issue <= '0;
                        end
                    end
                end
                S_EMIT: begin
                    if (em_rd) begin
                        r_issue <= r_issue + CNT_W'(1);
                    end
                    if (r_em_vld && em_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_rsp_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_rsp.valid |-> (r_state == S_SCAN))
        else $error("count returned outside the count pass");

    a_emit_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_em_vld |-> (r_state == S_EMIT))
        else $error("count read outside the result pass");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result transfer right after the last result");

    a_best_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_mode == tchs_pkg::MODE_BEST)) |-> (o_mismatch_count >= r_best))
        else $error("result count below the search minimum");

endmodule

`default_nettype wire
